>>> hw/rtl/oamc_pkg.sv
// ----------------------------------------------------------------------------
// OAM corruption model package
// Shared types, constants and codes for the sprite attribute memory block.
// ----------------------------------------------------------------------------
`default_nettype none

package oamc_pkg;

   localparam int ROW_COUNT  = 20;
   localparam int ROW_W      = 64;
   localparam int ROW_IDX_W  = $clog2(ROW_COUNT);

   typedef logic [ROW_IDX_W-1:0] row_idx_type;
   typedef logic [ROW_W-1:0]     row_type;

   localparam logic [7:0]  BYTE_COUNT     = 8'd160;
   localparam logic [8:0]  SCAN_DOT_LIMIT = 9'd80;
   localparam row_idx_type LAST_ROW       = row_idx_type'(ROW_COUNT - 1);
   localparam row_idx_type BLEND_MIN_ROW  = row_idx_type'(4);

   // Item actions.
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_EVENT = 2'd2;

   // Scan bus access kinds.
   localparam logic [1:0] KIND_READ     = 2'd0;
   localparam logic [1:0] KIND_WRITE    = 2'd1;
   localparam logic [1:0] KIND_READ_INC = 2'd2;

   localparam logic [1:0] MODE_SCAN = 2'd2;

   // Row selection for memory accesses.
   localparam logic [1:0] SEL_M2   = 2'd0;
   localparam logic [1:0] SEL_M1   = 2'd1;
   localparam logic [1:0] SEL_CUR  = 2'd2;
   localparam logic [1:0] SEL_ADDR = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] byte_address;
      logic [7:0] write_byte;
      logic [1:0] access_kind;
      logic       display_on;
      logic [1:0] pixel_mode;
      logic [8:0] scan_dot;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       corrupted;
   } rsp_type;

   typedef struct packed {
      logic       latch_item;
      logic       ram_rd;
      logic [1:0] rd_sel;
      logic       ram_wr;
      logic [1:0] wr_sel;
      logic       cap_m2;
      logic       cap_m1;
      logic       cap_cur;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic byte_op;
      logic byte_write;
      logic acting;
      logic triple;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/oamc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module oamc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 20,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/oamc_ctrl.sv
// ----------------------------------------------------------------------------
// OAM corruption model controller
// Sequences row reads, row writes and the result hand-off for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module oamc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire oamc_pkg::status_type   status,
   output oamc_pkg::cmd_type           cmd
);

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE      = 4'd0;
   localparam logic [STATE_W-1:0] S_DISPATCH  = 4'd1;
   localparam logic [STATE_W-1:0] S_RD_M1     = 4'd2;
   localparam logic [STATE_W-1:0] S_RD_CUR    = 4'd3;
   localparam logic [STATE_W-1:0] S_CAPT      = 4'd4;
   localparam logic [STATE_W-1:0] S_WR_M2     = 4'd5;
   localparam logic [STATE_W-1:0] S_WR_M1     = 4'd6;
   localparam logic [STATE_W-1:0] S_WR_CUR    = 4'd7;
   localparam logic [STATE_W-1:0] S_BYTE_CAPT = 4'd8;
   localparam logic [STATE_W-1:0] S_WR_BYTE   = 4'd9;
   localparam logic [STATE_W-1:0] S_DONE      = 4'd10;

   logic [STATE_W-1:0] state_ff;
   logic [STATE_W-1:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               state_in       = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.byte_op) begin
               cmd.ram_rd = 1'b1;
               cmd.rd_sel = oamc_pkg::SEL_ADDR;
               state_in   = S_BYTE_CAPT;
            end else if (status.triple) begin
               cmd.ram_rd = 1'b1;
               cmd.rd_sel = oamc_pkg::SEL_M2;
               state_in   = S_RD_M1;
            end else if (status.acting) begin
               cmd.ram_rd = 1'b1;
               cmd.rd_sel = oamc_pkg::SEL_M1;
               state_in   = S_RD_CUR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RD_M1: begin
            cmd.cap_m2 = 1'b1;
            cmd.ram_rd = 1'b1;
            cmd.rd_sel = oamc_pkg::SEL_M1;
            state_in   = S_RD_CUR;
         end
         S_RD_CUR: begin
            cmd.cap_m1 = 1'b1;
            cmd.ram_rd = 1'b1;
            cmd.rd_sel = oamc_pkg::SEL_CUR;
            state_in   = S_CAPT;
         end
         S_CAPT: begin
            cmd.cap_cur = 1'b1;
            state_in    = status.triple ? S_WR_M2 : S_WR_CUR;
         end
         S_WR_M2: begin
            cmd.ram_wr = 1'b1;
            cmd.wr_sel = oamc_pkg::SEL_M2;
            state_in   = S_WR_M1;
         end
         S_WR_M1: begin
            cmd.ram_wr = 1'b1;
            cmd.wr_sel = oamc_pkg::SEL_M1;
            state_in   = S_WR_CUR;
         end
         S_WR_CUR: begin
            cmd.ram_wr = 1'b1;
            cmd.wr_sel = oamc_pkg::SEL_CUR;
            state_in   = S_DONE;
         end
         S_BYTE_CAPT: begin
            cmd.cap_cur = 1'b1;
            state_in    = status.byte_write ? S_WR_BYTE : S_DONE;
         end
         S_WR_BYTE: begin
            cmd.ram_wr = 1'b1;
            cmd.wr_sel = oamc_pkg::SEL_ADDR;
            state_in   = S_DONE;
         end
         S_DONE: begin
            // Wait here while the previous result is still held by the sink.
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DISPATCH))
      else $error("accepted word did not move to dispatch");

   a_no_rd_wr_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ram_rd && cmd.ram_wr))
      else $error("row read and row write issued together");

endmodule

`default_nettype wire

>>> hw/rtl/oamc_dpath.sv
// ----------------------------------------------------------------------------
// OAM corruption model datapath
// Holds the word, the row memory, the fetched rows, the blend logic and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oamc_dpath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire oamc_pkg::req_type      req_data,
   input  wire oamc_pkg::cmd_type      cmd,
   output oamc_pkg::status_type        status,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output oamc_pkg::rsp_type           rsp_data
);

   oamc_pkg::req_type     item_ff;
   oamc_pkg::row_type     m2_ff;
   oamc_pkg::row_type     m1_ff;
   oamc_pkg::row_type     cur_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   oamc_pkg::rsp_type     rsp_data_ff;
   oamc_pkg::rsp_type     rsp_data_in;

   oamc_pkg::row_type     ram_rd_data;
   oamc_pkg::row_type     ram_wr_data;
   oamc_pkg::row_idx_type ram_rd_addr;
   oamc_pkg::row_idx_type ram_wr_addr;

   logic                  addr_ok;
   oamc_pkg::row_idx_type addr_row;
   logic [2:0]            lane;
   oamc_pkg::row_idx_type hit_row;
   oamc_pkg::row_idx_type row_m1;
   oamc_pkg::row_idx_type row_m2;
   logic                  acting;
   logic                  triple;

   logic [15:0]           blend_w0;
   oamc_pkg::row_type     blend_row;
   oamc_pkg::row_type     src_m1;
   logic [15:0]           word_a;
   logic [15:0]           word_b;
   logic [15:0]           word_c;
   logic [15:0]           first_w;
   oamc_pkg::row_type     final_row;
   logic                  changed;
   oamc_pkg::row_type     merged_row;
   logic [7:0]            lane_byte;

   // Decode of the held word.
   always_comb begin
      addr_ok  = (item_ff.byte_address < oamc_pkg::BYTE_COUNT);
      addr_row = item_ff.byte_address[7:3];
      lane     = item_ff.byte_address[2:0];
      // Only meaningful while the dot is below 80, which keeps the row in range.
      hit_row  = item_ff.scan_dot[6:2];
      row_m1   = hit_row - oamc_pkg::row_idx_type'(1);
      row_m2   = hit_row - oamc_pkg::row_idx_type'(2);
      acting   = (item_ff.action == oamc_pkg::ACT_EVENT) && item_ff.display_on &&
                 (item_ff.pixel_mode == oamc_pkg::MODE_SCAN) &&
                 (item_ff.scan_dot < oamc_pkg::SCAN_DOT_LIMIT) &&
                 (hit_row != '0);
      triple   = acting && (item_ff.access_kind == oamc_pkg::KIND_READ_INC) &&
                 (hit_row >= oamc_pkg::BLEND_MIN_ROW) && (hit_row != oamc_pkg::LAST_ROW);
   end

   always_comb begin
      status.byte_op    = ((item_ff.action == oamc_pkg::ACT_WRITE) ||
                           (item_ff.action == oamc_pkg::ACT_READ)) && addr_ok;
      status.byte_write = (item_ff.action == oamc_pkg::ACT_WRITE);
      status.acting     = acting;
      status.triple     = triple;
      status.out_busy   = rsp_valid_ff && rsp_stall;
   end

   // Four-word blend across the hit row and the two rows above it. The blended row
   // is written to both rows above the hit row and stands in for the previous row.
   always_comb begin
      blend_w0  = (m1_ff[15:0] & (m2_ff[15:0] | cur_ff[15:0] | m1_ff[47:32])) |
                  (m2_ff[15:0] & cur_ff[15:0] & m1_ff[47:32]);
      blend_row = {m1_ff[63:16], blend_w0};
      src_m1    = triple ? blend_row : m1_ff;
      word_a    = triple ? blend_w0 : cur_ff[15:0];
      word_b    = src_m1[15:0];
      word_c    = src_m1[47:32];
      if (item_ff.access_kind == oamc_pkg::KIND_WRITE) begin
         first_w = ((word_a ^ word_c) & (word_b ^ word_c)) ^ word_c;
      end else begin
         first_w = word_b | (word_a & word_c);
      end
      final_row = {src_m1[63:16], first_w};
      changed   = (final_row != cur_ff) ||
                  (triple && ((blend_w0 != m1_ff[15:0]) || (blend_row != m2_ff)));
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         merged_row[8*i +: 8] = (lane == 3'(i)) ? item_ff.write_byte : cur_ff[8*i +: 8];
      end
      lane_byte = cur_ff[{lane, 3'b000} +: 8];
   end

   always_comb begin
      case (cmd.rd_sel)
         oamc_pkg::SEL_M2:  ram_rd_addr = row_m2;
         oamc_pkg::SEL_M1:  ram_rd_addr = row_m1;
         oamc_pkg::SEL_CUR: ram_rd_addr = hit_row;
         default:           ram_rd_addr = addr_row;
      endcase
      case (cmd.wr_sel)
         oamc_pkg::SEL_M2: begin
            ram_wr_addr = row_m2;
            ram_wr_data = blend_row;
         end
         oamc_pkg::SEL_M1: begin
            ram_wr_addr = row_m1;
            ram_wr_data = blend_row;
         end
         oamc_pkg::SEL_CUR: begin
            ram_wr_addr = hit_row;
            ram_wr_data = final_row;
         end
         default: begin
            ram_wr_addr = addr_row;
            ram_wr_data = merged_row;
         end
      endcase
   end

   oamc_ram #(
      .WIDTH (oamc_pkg::ROW_W),
      .DEPTH (oamc_pkg::ROW_COUNT)
   ) u_rows (
      .clock   (clock),
      .wr_en   (cmd.ram_wr),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.ram_rd),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_data_in.read_byte = ((item_ff.action == oamc_pkg::ACT_READ) && addr_ok) ?
                              lane_byte : 8'd0;
      rsp_data_in.corrupted = acting && changed;
      rsp_valid_in          = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         item_ff <= req_data;
      end
      if (cmd.cap_m2) begin
         m2_ff <= ram_rd_data;
      end
      if (cmd.cap_m1) begin
         m1_ff <= ram_rd_data;
      end
      if (cmd.cap_cur) begin
         cur_ff <= ram_rd_data;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded while the sink still holds a word");

   a_corrupt_is_event: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && rsp_data_in.corrupted) |-> (item_ff.action == oamc_pkg::ACT_EVENT))
      else $error("corruption flagged for a byte access");

   a_upper_row_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.ram_wr && ((cmd.wr_sel == oamc_pkg::SEL_M2) || (cmd.wr_sel == oamc_pkg::SEL_M1)))
      |-> triple)
      else $error("rows above the hit row written outside the four-word blend");

endmodule

`default_nettype wire

>>> hw/rtl/oam_corruption_model.sv
// ----------------------------------------------------------------------------
// OAM corruption model
// Sprite attribute memory of twenty 64-bit rows with byte access and the
// scan-bus corruption effect applied on event words.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  req      in         req_valid / req_stall   oamc_pkg::req_type req_data
//  rsp      out        rsp_valid / rsp_stall   oamc_pkg::rsp_type rsp_data
//
//  One word is in work at a time; the row memory has one read and one write
//  port, so rows are fetched and stored one per cycle. Reset is synchronous
//  and clears control only; memory contents are undefined until written.
//  The next word is taken while a result waits in the output register; a
//  stalled sink holds back only the hand-off of the following result.
// ----------------------------------------------------------------------------
`default_nettype none

module oam_corruption_model (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire oamc_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output oamc_pkg::rsp_type        rsp_data
);

   oamc_pkg::cmd_type    cmd;
   oamc_pkg::status_type status;

   oamc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   oamc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
